### src/zrhd_pkg.sv
// Package for the zero-run hole detector: item and result types, result kinds,
// queue sizing and configuration reset value. No dependencies.
package zrhd_pkg;

	localparam int OFS_W     = 63;
	localparam int THR_W     = 16;
	localparam int MAX_RES   = 3;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int NRES_W    = $clog2(MAX_RES + 1);

	localparam logic [THR_W-1:0] THR_RESET = 16'd1024;

	typedef enum logic [1:0] {
		KIND_SEGMENT = 2'd0,
		KIND_HOLE    = 2'd1,
		KIND_REPORT  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic             first_of_buffer;
		logic             last_of_buffer;
		logic [OFS_W-1:0] buffer_offset;
	} item_t;

	typedef struct packed {
		kind_t            kind;
		logic [OFS_W-1:0] range_start;
		logic [OFS_W-1:0] range_end;
		logic             last_result;
	} result_t;

	// results produced by one byte, slot 0 first
	typedef struct packed {
		logic [NRES_W-1:0]         count;
		result_t [MAX_RES-1:0]     res;
	} push_t;

endpackage

### src/zrhd_core.sv
// Segment/hole decision for one registered byte, plus the offset and zero-run state
// and the threshold register. Depends on zrhd_pkg.
module zrhd_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  zrhd_pkg::item_t            item_s1,
	input  logic                       cfg_we,
	input  logic [zrhd_pkg::THR_W-1:0] cfg_data,
	output zrhd_pkg::push_t            push
);
	import zrhd_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic [OFS_W-1:0] cur_q, hole_q, seg_start_q, zstart_q;
	logic [THR_W-1:0] zlen_q;
	logic             in_seg_q;

	logic [OFS_W-1:0] off, off_inc, gap, end_ofs;
	logic [THR_W-1:0] eff, zlen0, zinc, zlen1, zlen2;
	logic             seg0, seg1, seg2, nz;
	logic             hole_emit, seg_emit, close;
	logic [OFS_W-1:0] seg_start1, zstart1, hole1, hole2, seg_end;
	logic [NRES_W-1:0] k;

	always_comb begin
		off     = item_s1.first_of_buffer ? item_s1.buffer_offset : cur_q;
		off_inc = off + OFS_W'(1);
		eff     = (thr_q == '0) ? THR_W'(1) : thr_q;
		seg0    = item_s1.first_of_buffer ? 1'b0 : in_seg_q;
		zlen0   = item_s1.first_of_buffer ? '0 : zlen_q;
		nz      = item_s1.data_byte != 8'd0;
		gap     = off - hole_q;
		zinc    = (zlen0 < eff) ? zlen0 + THR_W'(1) : zlen0;

		hole_emit  = 1'b0;
		seg_emit   = 1'b0;
		close      = 1'b0;
		seg_start1 = seg_start_q;
		zstart1    = zstart_q;
		hole1      = hole_q;
		seg1       = seg0;
		zlen1      = zlen0;
		seg_end    = zstart_q;

		if (nz) begin
			if (!seg0) begin
				hole_emit  = gap >= OFS_W'(thr_q);
				seg_start1 = off;
			end
			seg1  = 1'b1;
			zlen1 = '0;
		end else if (seg0) begin
			if (zlen0 == '0) zstart1 = off;
			close = zinc >= eff;
			if (close) begin
				seg_emit = 1'b1;
				seg_end  = zstart1;
				hole1    = zstart1;
				seg1     = 1'b0;
				zlen1    = '0;
			end else begin
				zlen1 = zinc;
			end
		end

		// buffer end flushes an open segment, trailing zeros excluded
		end_ofs = (zlen1 != '0) ? zstart1 : off_inc;
		hole2   = hole1;
		seg2    = seg1;
		zlen2   = zlen1;
		if (item_s1.last_of_buffer && seg1) begin
			seg_emit = 1'b1;
			seg_end  = end_ofs;
			hole2    = end_ofs;
			seg2     = 1'b0;
			zlen2    = '0;
		end

		// order within one byte: hole, segment, report
		push.res = '0;
		k        = '0;
		if (hole_emit) begin
			push.res[k].kind        = KIND_HOLE;
			push.res[k].range_start = hole_q;
			push.res[k].range_end   = off;
			k = k + NRES_W'(1);
		end
		if (seg_emit) begin
			push.res[k].kind        = KIND_SEGMENT;
			push.res[k].range_start = seg_start1;
			push.res[k].range_end   = seg_end;
			k = k + NRES_W'(1);
		end
		if (item_s1.last_of_buffer) begin
			push.res[k].kind        = KIND_REPORT;
			push.res[k].range_start = hole2;
			push.res[k].range_end   = '0;
			k = k + NRES_W'(1);
		end
		for (int i = 0; i < MAX_RES; i++) begin
			push.res[i].last_result = (NRES_W'(i) == k - NRES_W'(1));
		end
		push.count = fire ? k : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			cur_q       <= '0;
			hole_q      <= '0;
			seg_start_q <= '0;
			zstart_q    <= '0;
			zlen_q      <= '0;
			in_seg_q    <= 1'b0;
		end else begin
			if (cfg_we) thr_q <= cfg_data;
			if (fire) begin
				cur_q       <= off_inc;
				hole_q      <= hole2;
				seg_start_q <= seg_start1;
				zstart_q    <= zstart1;
				zlen_q      <= zlen2;
				in_seg_q    <= seg2;
			end
		end
	end

	// an end-of-buffer byte always closes with a report
	a_last_report: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.last_of_buffer |->
			push.count != '0 && push.res[push.count - NRES_W'(1)].kind == KIND_REPORT)
		else $error("buffer end without trailing report");

	// without buffer end at most a hole or a segment comes out
	a_mid_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !item_s1.last_of_buffer |-> push.count <= NRES_W'(1))
		else $error("too many results for a mid-buffer byte");

	// no segment stays open past a buffer end
	a_closed: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.last_of_buffer |=> !in_seg_q && zlen_q == '0)
		else $error("segment left open after buffer end");

endmodule

### src/zrhd_fifo.sv
// Result queue: takes up to three results per cycle, hands out one per transfer.
// Depends on zrhd_pkg.
module zrhd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  zrhd_pkg::push_t   push,
	output logic              room,
	output logic              result_valid,
	input  logic              result_stall,
	output zrhd_pkg::result_t result
);
	import zrhd_pkg::*;

	result_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                pop;

	assign result_valid = cnt_q != '0;
	assign result       = mem_q[rd_q];
	assign pop          = result_valid && !result_stall;
	assign room         = cnt_q <= QCNT_W'(QDEPTH - MAX_RES);

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (NRES_W'(i) < push.count) mem_q[wr_q + QPTR_W'(i)] <= push.res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.count);
			if (pop) rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != '0 |-> cnt_q <= QCNT_W'(QDEPTH - MAX_RES))
		else $error("result queue written without room");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == QCNT_W'(1) && pop && push.count == '0 |=> !result_valid)
		else $error("queue count wrong after last transfer");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && push.count != '0 |=> result_valid)
		else $error("pushed result not presented");

endmodule

### src/zero_run_hole_detector.sv
// Top level of the zero-run hole detector: input register, decision core, result queue.
// Depends on zrhd_pkg, zrhd_core, zrhd_fifo.
//
// Takes one buffer byte per cycle while not stalled and splits the byte stream into
// data segments (kind 0), holes (kind 1) and an end-of-buffer report (kind 2)
// carrying the new hole start. A byte is registered, decided once the queue has room,
// and its results (zero to three; last_result marks the final one) enter a four-entry
// queue, from which they are offered. The queue drains one result per cycle while
// results are not stalled; the input stalls while it cannot take three more, so the
// byte rate is one per cycle while no byte yields more than one result and results
// are taken without stall; a byte with two or three results can stall the input.
// The user must write hole_threshold via cfg_we/cfg_data only while idle (unenforced).
module zero_run_hole_detector (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  zrhd_pkg::item_t            item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output zrhd_pkg::result_t          result,
	input  logic                       cfg_we,
	input  logic [zrhd_pkg::THR_W-1:0] cfg_data
);
	import zrhd_pkg::*;

	item_t  item_s1;
	logic   valid_s1;
	logic   fire, room, accept;
	push_t  push;

	assign fire       = valid_s1 && room;
	assign item_stall = valid_s1 && !room;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !fire);
		end
	end

	zrhd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item_s1  (item_s1),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.push     (push)
	);

	zrhd_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(item_s1))
		else $error("registered byte lost while waiting");

	a_push_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |-> push.count == '0)
		else $error("results pushed without a byte");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted byte not registered");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Testbench for zero_run_hole_detector: a directed table, then random buffers under several
// hole thresholds, results checked against typed-in values or an in-bench segment/hole predictor.
// Depends on zrhd_pkg and the detector RTL; reads nothing else.
module testbench;
	import zrhd_pkg::*;

	localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};
	localparam logic [OFS_W-1:0] JUNK_OFS = 63'h2AAA_AAAA_5555_5555;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 22;
	localparam int NUM_PHASES = 6;

	typedef struct packed {
		item_t                 it;
		logic                  typed;
		logic [1:0]            nres;
		result_t [MAX_RES-1:0] res;
	} stim_t;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	item_t             item;
	logic              result_valid;
	logic              result_stall;
	result_t           result;
	logic              cfg_we;
	logic [THR_W-1:0]  cfg_data;

	// bytes waiting to go out, and results still owed by the block
	stim_t   byte_plan [$];
	result_t pending_ranges [$];

	// typed-in results of the byte currently offered
	logic                  drv_typed;
	logic [1:0]            drv_nres;
	result_t [MAX_RES-1:0] drv_res;

	int tx_idle_pct = 30;
	int rx_idle_pct = 62;
	bit hold_req = 1'b0;
	int errors = 0;
	int cycle_cnt = 0;
	logic [OFS_W-1:0] gen_ofs = '0;

	// predictor state
	logic [THR_W-1:0] thr_model = THR_RESET;
	logic [OFS_W-1:0] ofs_next = '0;
	logic [OFS_W-1:0] hole_at = '0;
	logic [OFS_W-1:0] seg_at = '0;
	logic [OFS_W-1:0] zrun_at = '0;
	int               zrun_len = 0;
	bit               seg_open = 1'b0;

	zero_run_hole_detector uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic result_t mk_range(input kind_t k, input logic [OFS_W-1:0] s,
			input logic [OFS_W-1:0] e, input logic lr);
		result_t r;
		r.kind = k;
		r.range_start = s;
		r.range_end = e;
		r.last_result = lr;
		return r;
	endfunction

	// Splits one byte into hole / segment / end-of-buffer results, in that order.
	function automatic int split_byte(input item_t b, output result_t [MAX_RES-1:0] r);
		logic [OFS_W-1:0] off;
		logic [OFS_W-1:0] gap;
		logic [OFS_W-1:0] fin;
		int eff;
		int n;
		n = 0;
		r = '0;
		off = b.first_of_buffer ? b.buffer_offset : ofs_next;
		eff = (thr_model == 0) ? 1 : int'(thr_model);
		if (b.first_of_buffer) begin
			// an open segment without its buffer end is dropped
			seg_open = 1'b0;
			zrun_len = 0;
		end
		if (b.data_byte != 8'h00) begin
			if (!seg_open) begin
				gap = off - hole_at;
				if (gap >= thr_model) begin
					r[n] = mk_range(KIND_HOLE, hole_at, off, 1'b0);
					n++;
				end
				seg_at = off;
				seg_open = 1'b1;
			end
			zrun_len = 0;
		end else if (seg_open) begin
			if (zrun_len == 0)
				zrun_at = off;
			if (zrun_len < eff)
				zrun_len++;
			if (zrun_len >= eff) begin
				r[n] = mk_range(KIND_SEGMENT, seg_at, zrun_at, 1'b0);
				n++;
				hole_at = zrun_at;
				seg_open = 1'b0;
				zrun_len = 0;
			end
		end
		if (b.last_of_buffer) begin
			if (seg_open) begin
				// trailing zeros are not written
				fin = (zrun_len != 0) ? zrun_at : off + 1'b1;
				r[n] = mk_range(KIND_SEGMENT, seg_at, fin, 1'b0);
				n++;
				hole_at = fin;
				seg_open = 1'b0;
				zrun_len = 0;
			end
			r[n] = mk_range(KIND_REPORT, hole_at, '0, 1'b0);
			n++;
		end
		if (n > 0)
			r[n-1].last_result = 1'b1;
		ofs_next = off + 1'b1;
		return n;
	endfunction

	task automatic flag_result(input string what, input result_t want, input result_t got);
		errors++;
		if (errors <= 10)
			$display("%s: expected kind=%0d start=%h end=%h last=%b, got kind=%0d start=%h end=%h last=%b",
				what, want.kind, want.range_start, want.range_end, want.last_result,
				got.kind, got.range_start, got.range_end, got.last_result);
	endtask

	always @(posedge clk) begin : check_edge
		result_t want;
		result_t [MAX_RES-1:0] pred;
		int n;
		int k;
		if (arst_n) begin
			if (cfg_we)
				thr_model = cfg_data;
			if (result_valid && !result_stall) begin
				if (pending_ranges.size() == 0) begin
					flag_result("unexpected result", '0, result);
				end else begin
					want = pending_ranges.pop_front();
					if (result !== want)
						flag_result("result mismatch", want, result);
				end
			end
			if (item_valid && !item_stall) begin
				n = split_byte(item, pred);
				if (drv_typed) begin
					for (k = 0; k < drv_nres; k++)
						pending_ranges.push_back(drv_res[k]);
				end else begin
					for (k = 0; k < n; k++)
						pending_ranges.push_back(pred[k]);
				end
			end
		end
	end

	// receiver: random stall, or a long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	function automatic void queue_byte(input logic [7:0] d, input logic f, input logic l,
			input logic [OFS_W-1:0] o, input logic typed, input logic [1:0] n,
			input result_t r0, input result_t r1, input result_t r2);
		stim_t s;
		s.it.data_byte = d;
		s.it.first_of_buffer = f;
		s.it.last_of_buffer = l;
		s.it.buffer_offset = o;
		s.typed = typed;
		s.nres = n;
		s.res[0] = r0;
		s.res[1] = r1;
		s.res[2] = r2;
		byte_plan.push_back(s);
	endfunction

	function automatic logic [OFS_W-1:0] wide_ofs();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[OFS_W-1:0];
	endfunction

	// zero run lengths clustered around the threshold when it is reachable
	function automatic int zero_len(input int eff);
		int pick;
		pick = $urandom_range(3);
		if (eff > 12)
			return $urandom_range(1, 6);
		case (pick)
			0: return eff - 1;
			1: return eff;
			2: return eff + 1;
			default: return $urandom_range(1, eff + 1);
		endcase
	endfunction

	task automatic plan_random(input int count, input int thr);
		logic [7:0] body [$];
		logic [OFS_W-1:0] start;
		int eff;
		int pick;
		int k;
		bit broken;
		eff = (thr == 0) ? 1 : thr;
		while (count > 0) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				// stray byte with no buffer start: continues at the current offset
				queue_byte(8'($urandom_range(255)), 1'b0, $urandom_range(99) < 40, wide_ofs(),
					1'b0, 2'd0, '0, '0, '0);
				gen_ofs++;
				count--;
			end else begin
				body.delete();
				if (pick < 14) begin
					repeat ($urandom_range(1, 4)) body.push_back(8'h00);
				end else begin
					if ($urandom_range(99) < 40)
						repeat (zero_len(eff)) body.push_back(8'h00);
					repeat ($urandom_range(1, 3)) begin
						repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(1, 255)));
						if ($urandom_range(99) < 75)
							repeat (zero_len(eff)) body.push_back(8'h00);
					end
				end
				pick = $urandom_range(99);
				if (pick < 70)
					start = gen_ofs + $urandom_range(0, 3 * eff);
				else if (pick < 85)
					start = wide_ofs();
				else
					start = OFS_MAX - $urandom_range(0, 6);
				broken = ($urandom_range(99) < 10);
				for (k = 0; k < body.size(); k++)
					queue_byte(body[k], k == 0, !broken && (k == body.size() - 1),
						(k == 0) ? start : wide_ofs(), 1'b0, 2'd0, '0, '0, '0);
				gen_ofs = start + body.size();
				count -= body.size();
			end
		end
	endtask

	task automatic run_plan();
		stim_t s;
		while (byte_plan.size() != 0) begin
			s = byte_plan.pop_front();
			@(negedge clk);
			while ($urandom_range(99) < tx_idle_pct) begin
				item_valid <= 1'b0;
				@(negedge clk);
			end
			item_valid <= 1'b1;
			item <= s.it;
			drv_typed = s.typed;
			drv_nres = s.nres;
			drv_res = s.res;
			do begin
				@(posedge clk);
			end while (item_stall);
		end
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	// wait until every owed result is in, plus the pipeline depth for result-less bytes
	task automatic drain();
		while (pending_ranges.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin : stimulus
		int p;
		int thr;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_data = THR_RESET;
		drv_typed = 1'b0;
		drv_nres = '0;
		drv_res = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// reset threshold; single-byte buffers first, then chaining and special cases
		queue_byte(8'hFF, 1'b1, 1'b1, '0, 1'b1, 2'd2,
			mk_range(KIND_SEGMENT, 0, 1, 1'b0), mk_range(KIND_REPORT, 1, 0, 1'b1), '0);
		queue_byte(8'h01, 1'b1, 1'b1, OFS_MAX, 1'b1, 2'd3,
			mk_range(KIND_HOLE, 1, OFS_MAX, 1'b0), mk_range(KIND_SEGMENT, OFS_MAX, 0, 1'b0),
			mk_range(KIND_REPORT, 0, 0, 1'b1));
		queue_byte(8'h80, 1'b1, 1'b0, 63'd5, 1'b1, 2'd0, '0, '0, '0);
		queue_byte(8'h00, 1'b0, 1'b0, JUNK_OFS, 1'b0, 2'd0, '0, '0, '0);
		queue_byte(8'h00, 1'b0, 1'b0, JUNK_OFS, 1'b0, 2'd0, '0, '0, '0);
		queue_byte(8'h7F, 1'b0, 1'b0, ~JUNK_OFS, 1'b0, 2'd0, '0, '0, '0);
		queue_byte(8'h00, 1'b0, 1'b1, JUNK_OFS, 1'b0, 2'd0, '0, '0, '0);
		// buffer left open, then a new buffer start far away
		queue_byte(8'h11, 1'b1, 1'b0, 63'd100, 1'b0, 2'd0, '0, '0, '0);
		queue_byte(8'h22, 1'b1, 1'b0, 63'd3000, 1'b0, 2'd0, '0, '0, '0);
		queue_byte(8'h00, 1'b0, 1'b1, JUNK_OFS, 1'b0, 2'd0, '0, '0, '0);
		// bytes with no buffer start
		queue_byte(8'h00, 1'b0, 1'b0, ~JUNK_OFS, 1'b0, 2'd0, '0, '0, '0);
		queue_byte(8'h55, 1'b0, 1'b1, JUNK_OFS, 1'b0, 2'd0, '0, '0, '0);
		// leading zeros extend the previous gap
		queue_byte(8'h00, 1'b1, 1'b0, 63'd4000, 1'b0, 2'd0, '0, '0, '0);
		queue_byte(8'h00, 1'b0, 1'b0, JUNK_OFS, 1'b0, 2'd0, '0, '0, '0);
		queue_byte(8'h01, 1'b0, 1'b1, JUNK_OFS, 1'b0, 2'd0, '0, '0, '0);
		// all-zero buffer at the top offset, then a hole that wraps
		queue_byte(8'h00, 1'b1, 1'b1, OFS_MAX, 1'b0, 2'd0, '0, '0, '0);
		queue_byte(8'h00, 1'b1, 1'b0, '0, 1'b0, 2'd0, '0, '0, '0);
		queue_byte(8'hAA, 1'b0, 1'b1, ~JUNK_OFS, 1'b0, 2'd0, '0, '0, '0);
		run_plan();

		for (p = 0; p < NUM_PHASES; p++) begin
			drain();
			case (p)
				0: thr = 1;
				1: thr = 0;
				2: thr = 65535;
				3: thr = 3;
				4: thr = 2;
				default: thr = $urandom_range(4, 9);
			endcase
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_data <= thr[THR_W-1:0];
			@(negedge clk);
			cfg_we <= 1'b0;
			if (p < 2) begin
				tx_idle_pct = 30;
				rx_idle_pct = 62;
			end else if (p < 4) begin
				tx_idle_pct = 62;
				rx_idle_pct = 30;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			// long receiver hold-off while bytes keep coming: fills the result queue
			if (p == 4)
				hold_req = 1'b1;
			plan_random(PHASE_ITEMS, thr);
			run_plan();
		end

		drain();
		if (errors == 0 && pending_ranges.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### files.f
src/zrhd_pkg.sv
src/zrhd_core.sv
src/zrhd_fifo.sv
src/zero_run_hole_detector.sv
test/testbench.sv
